@@ rtl/rrd_pkg.sv @@
package rrd_pkg;

  // Fixed field widths of the command and result beats.
  localparam int POS_W  = 10;
  localparam int WORD_W = 64;
  localparam int OCC_W  = 11;

  // Command codes carried in the action field.
  typedef enum logic [3:0] {
    ACT_PUSH_L = 4'd0,
    ACT_PUSH_R = 4'd1,
    ACT_POP_L  = 4'd2,
    ACT_POP_R  = 4'd3,
    ACT_PEEK_L = 4'd4,
    ACT_PEEK_R = 4'd5,
    ACT_GET    = 4'd6,
    ACT_SET    = 4'd7,
    ACT_REV    = 4'd8
  } rrd_act_t;

  // Status codes returned with every result.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } rrd_status_t;

  typedef struct packed {
    logic [3:0]               action;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] word_in;
  } rrd_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word_out;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;
    logic                     is_empty;
    logic                     reversed_now;
  } rrd_out_t;

  // Strobes from the pointer logic to the ring memory.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } rrd_mem_cmd_t;

endpackage

@@ rtl/rrd_ring.sv @@
module rrd_ring import rrd_pkg::*; #(
  parameter int CAPACITY = 1024,
  localparam int PW = $clog2(CAPACITY)
) (
  input  logic                     clk,
  input  rrd_mem_cmd_t             mem_cmd,
  input  logic [PW-1:0]            mem_addr,
  input  logic signed [WORD_W-1:0] mem_wdata,
  output logic signed [WORD_W-1:0] mem_rdata
);

  logic signed [WORD_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (mem_cmd.wr_en) begin
      mem[mem_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_cmd.rd_en) begin
      mem_rdata <= mem[mem_addr];
    end
  end

endmodule

@@ rtl/rrd_ptr.sv @@
module rrd_ptr import rrd_pkg::*; #(
  parameter int CAPACITY = 1024,
  localparam int PW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  rrd_in_t                  cmd,
  output rrd_mem_cmd_t             mem_cmd,
  output logic [PW-1:0]            mem_addr,
  output logic signed [WORD_W-1:0] mem_wdata,
  output rrd_out_t                 res
);

  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int SW = PW + 1;

  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;

  logic          is_full, is_zero, in_range, head_side;
  logic [XW-1:0] idx;
  logic [PW-1:0] idx_p, head_inc, head_dec, tail_inc, tail_dec, slot;
  logic [SW-1:0] fwd_s, bwd_s;
  rrd_mem_cmd_t  cmd_raw;

  assign is_full = (count_r == CW'(CAPACITY));
  assign is_zero = (count_r == '0);

  assign head_inc = (head_r == PW'(CAPACITY - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? PW'(CAPACITY - 1) : head_r - 1'b1;
  assign tail_inc = (tail_r == PW'(CAPACITY - 1)) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? PW'(CAPACITY - 1) : tail_r - 1'b1;

  // Logical index of the addressed element; peeks address the two ends.
  always_comb begin
    case (cmd.action)
      ACT_PEEK_L: idx = '0;
      ACT_PEEK_R: idx = XW'(count_r) - 1'b1;
      default:    idx = XW'(cmd.position);
    endcase
  end

  assign in_range = (idx < XW'(count_r));
  assign idx_p    = PW'(idx);

  // Map the logical index onto a ring slot. Both sums stay below twice the
  // capacity, so one conditional subtract wraps them.
  assign fwd_s = SW'(head_r) + SW'(idx_p);
  assign bwd_s = SW'(tail_r) + SW'(CAPACITY - 1) - SW'(idx_p);

  always_comb begin
    if (!rev_r) begin
      slot = (fwd_s >= SW'(CAPACITY)) ? PW'(fwd_s - SW'(CAPACITY)) : PW'(fwd_s);
    end else begin
      slot = (bwd_s >= SW'(CAPACITY)) ? PW'(bwd_s - SW'(CAPACITY)) : PW'(bwd_s);
    end
  end

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    rev_nxt      = rev_r;
    cmd_raw      = '0;
    mem_addr     = slot;
    mem_wdata    = cmd.word_in;
    res          = '0;
    head_side    = 1'b0;
    case (cmd.action)
      ACT_PUSH_L, ACT_PUSH_R: begin
        head_side = (cmd.action == ACT_PUSH_L) ? !rev_r : rev_r;
        if (is_full) begin
          res.status = ST_FULL;
        end else begin
          cmd_raw.wr_en = 1'b1;
          count_nxt     = count_r + 1'b1;
          if (head_side) begin
            head_nxt = head_dec;
            mem_addr = head_dec;
          end else begin
            tail_nxt = tail_inc;
            mem_addr = tail_r;
          end
        end
      end
      ACT_POP_L, ACT_POP_R: begin
        head_side = (cmd.action == ACT_POP_L) ? !rev_r : rev_r;
        if (is_zero) begin
          res.status = ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
          if (head_side) begin
            head_nxt = head_inc;
          end else begin
            tail_nxt = tail_dec;
          end
        end
      end
      ACT_PEEK_L, ACT_PEEK_R, ACT_GET: begin
        if (!in_range) begin
          res.status   = (cmd.action == ACT_GET) ? ST_RANGE : ST_EMPTY;
          res.word_out = '1;
        end else begin
          cmd_raw.rd_en = 1'b1;
        end
      end
      ACT_SET: begin
        if (!in_range) begin
          res.status = ST_RANGE;
        end else begin
          cmd_raw.wr_en = 1'b1;
        end
      end
      ACT_REV: begin
        rev_nxt = !rev_r;
      end
      default: begin
      end
    endcase
    res.occupancy    = OCC_W'(count_nxt);
    res.is_empty     = (count_nxt == '0);
    res.reversed_now = rev_nxt;
  end

  assign mem_cmd.wr_en = accept & cmd_raw.wr_en;
  assign mem_cmd.rd_en = accept & cmd_raw.rd_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
    end else if (accept) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
    end
  end

endmodule

@@ rtl/reversible_ring_deque_top.sv @@
// Push, pop, set, reverse and failed reads give their result beat in the
// cycle after acceptance; successful peek and get register the memory word,
// then the merged result. Non-reading commands: one per cycle while the
// output does not stall; a read blocks new commands until its word is merged.
// Reset (synchronous, active low) empties the deque and clears reversal;
// the ring memory itself is not cleared.
module reversible_ring_deque_top import rrd_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  rrd_in_t in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output rrd_out_t out_data
);

  localparam int PW = $clog2(CAPACITY);

  // The control has two phases: taking commands, and waiting for the ring
  // memory to return the word of a peek or get.
  typedef enum logic [1:0] {
    S_TAKE  = 2'b01,
    S_FETCH = 2'b10
  } rrd_state_t;

  rrd_state_t               state_r, state_nxt;
  logic                     out_valid_r, out_valid_nxt;
  rrd_out_t                 out_data_r, out_data_nxt;
  rrd_out_t                 hold_r, hold_nxt;
  logic                     accept;
  rrd_mem_cmd_t             mem_cmd;
  logic [PW-1:0]            mem_addr;
  logic signed [WORD_W-1:0] mem_wdata, mem_rdata;
  rrd_out_t                 res;

  // A new command beat is taken unless a read is in flight or the result
  // register holds a beat that will not leave in this cycle. The result
  // register therefore frees itself in the same cycle it is refilled.
  assign in_stall = (state_r == S_FETCH) | (out_valid_r & out_stall);
  assign accept   = in_valid & ~in_stall;

  rrd_ptr #(.CAPACITY(CAPACITY)) u_ptr (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .cmd      (in_data),
    .mem_cmd  (mem_cmd),
    .mem_addr (mem_addr),
    .mem_wdata(mem_wdata),
    .res      (res)
  );

  rrd_ring #(.CAPACITY(CAPACITY)) u_ring (
    .clk      (clk),
    .mem_cmd  (mem_cmd),
    .mem_addr (mem_addr),
    .mem_wdata(mem_wdata),
    .mem_rdata(mem_rdata)
  );

  // Result assembly. A read parks the rest of its result in a holding
  // register and merges the memory word in the following cycle. Since a read
  // is only accepted when the result register is empty or drains in that same
  // cycle, the register is always empty when the merged beat arrives.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    hold_nxt      = hold_r;
    case (state_r)
      S_FETCH: begin
        out_valid_nxt         = 1'b1;
        out_data_nxt          = hold_r;
        out_data_nxt.word_out = mem_rdata;
        state_nxt             = S_TAKE;
      end
      S_TAKE: begin
        if (accept) begin
          if (mem_cmd.rd_en) begin
            hold_nxt  = res;
            state_nxt = S_FETCH;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = res;
          end
        end
      end
      default: begin
        state_nxt = S_TAKE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_TAKE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    hold_r     <= hold_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The result register must be free whenever a read word comes back.
  a_fetch_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH) |-> !out_valid_r)
    else $error("result register occupied while a read word returns");

  // Every read in flight turns into a result beat on the next cycle.
  a_fetch_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH) |=> (out_valid_r && state_r == S_TAKE))
    else $error("read word not delivered after one cycle");

  // The memory is never read and written for the same command.
  a_mem_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_cmd.wr_en && mem_cmd.rd_en))
    else $error("ring memory read and written by one command");

  // The empty flag agrees with the reported occupancy.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.is_empty == (out_data_r.occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

endmodule

@@ tb/sv/tb_reversible_ring_deque_top.sv @@
module tb_reversible_ring_deque_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rrd_pkg::*;

  // Deque depth used by both the block and the scoreboard model.
  localparam int unsigned CAP = 1024;
  // Largest code the action field can carry, and the first code with no meaning.
  localparam logic [3:0] ACT_CODE_MAX = 4'hF;
  localparam logic [3:0] ACT_FIRST_UNUSED = 4'(ACT_REV) + 4'd1;
  localparam int unsigned POS_MAX = (1 << POS_W) - 1;
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  // Cycles allowed for outstanding beats to come back before they are called lost.
  localparam int unsigned DRAIN_LIMIT = 20000;
  // Quiet cycles after the last result, well past the read latency.
  localparam int unsigned TAIL_CYCLES = 16;
  // Lines of mismatch detail printed before the report goes quiet.
  localparam int unsigned PRINT_LIMIT = 40;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  rrd_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rrd_out_t out_data;

  reversible_ring_deque_top #(
    .CAPACITY(CAP)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Percent chance, per cycle, that the sender holds back or the receiver stalls.
  // The fill-to-capacity test changes these to get bursts with no idling at all.
  int unsigned idle_pct = 37;
  int unsigned stall_pct = 37;

  int unsigned errors = 0;

  // Scoreboard model of the deque: ring of words, front and back pointers,
  // element count and the reversal flag. Updated when a command beat is accepted.
  logic signed [WORD_W-1:0] deque_words [CAP];
  int unsigned deque_front = 0;
  int unsigned deque_back = 0;
  int unsigned deque_len = 0;
  logic        deque_flipped = 1'b0;

  // Result beats still owed by the block, oldest first.
  rrd_out_t pending_results [$];
  rrd_out_t owed;

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (errors < PRINT_LIMIT)
      $display("%0t mismatch, %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Physical pushes and pops; at_front means the head side of the ring.
  function automatic rrd_status_t deque_push(logic at_front, logic signed [WORD_W-1:0] w);
    if (deque_len >= CAP)
      return ST_FULL;
    if (at_front) begin
      deque_front = (deque_front + CAP - 1) % CAP;
      deque_words[deque_front] = w;
    end else begin
      deque_words[deque_back] = w;
      deque_back = (deque_back + 1) % CAP;
    end
    deque_len++;
    return ST_OK;
  endfunction

  function automatic rrd_status_t deque_pop(logic at_front);
    if (deque_len == 0)
      return ST_EMPTY;
    if (at_front)
      deque_front = (deque_front + 1) % CAP;
    else
      deque_back = (deque_back + CAP - 1) % CAP;
    deque_len--;
    return ST_OK;
  endfunction

  // Ring slot of logical index i; while reversed, index zero sits just before the back.
  function automatic int unsigned deque_slot(int unsigned i);
    if (deque_flipped)
      return (deque_back + CAP - 1 - i) % CAP;
    return (deque_front + i) % CAP;
  endfunction

  // Applies one command to the model and returns the result beat it should cause.
  function automatic rrd_out_t predict_result(rrd_in_t c);
    rrd_out_t    r;
    logic        left_front;
    int unsigned p;
    r = '0;
    left_front = !deque_flipped;
    p = c.position;
    case (c.action)
      ACT_PUSH_L: r.status = deque_push(left_front, c.word_in);
      ACT_PUSH_R: r.status = deque_push(!left_front, c.word_in);
      ACT_POP_L:  r.status = deque_pop(left_front);
      ACT_POP_R:  r.status = deque_pop(!left_front);
      ACT_PEEK_L, ACT_PEEK_R: begin
        if (deque_len == 0) begin
          r.status = ST_EMPTY;
          r.word_out = '1;
        end else begin
          r.word_out = deque_words[deque_slot(c.action == ACT_PEEK_L ? 0 : deque_len - 1)];
        end
      end
      ACT_GET: begin
        if (p >= deque_len) begin
          r.status = ST_RANGE;
          r.word_out = '1;
        end else begin
          r.word_out = deque_words[deque_slot(p)];
        end
      end
      ACT_SET: begin
        if (p >= deque_len)
          r.status = ST_RANGE;
        else
          deque_words[deque_slot(p)] = c.word_in;
      end
      ACT_REV: deque_flipped = !deque_flipped;
      default: ;
    endcase
    r.occupancy = OCC_W'(deque_len);
    r.is_empty = (deque_len == 0);
    r.reversed_now = deque_flipped;
    return r;
  endfunction

  function automatic rrd_in_t make_cmd(logic [3:0] act, int unsigned pos,
                                       logic signed [WORD_W-1:0] w);
    rrd_in_t c;
    c.action = act;
    c.position = POS_W'(pos);
    c.word_in = w;
    return c;
  endfunction

  // Random command. Positions mostly land inside the current length so that get
  // and set do real work; the rest span the whole field and mostly miss.
  function automatic rrd_in_t next_random_cmd(int unsigned push_pct, int unsigned pop_pct);
    rrd_in_t     c;
    int unsigned r;
    c.word_in = {$urandom, $urandom};
    if (deque_len > 0 && $urandom_range(9) < 8)
      c.position = POS_W'($urandom_range(deque_len - 1));
    else
      c.position = POS_W'($urandom_range(POS_MAX));
    r = $urandom_range(99);
    if (r < push_pct) begin
      c.action = $urandom_range(1) ? ACT_PUSH_L : ACT_PUSH_R;
    end else if (r < push_pct + pop_pct) begin
      c.action = $urandom_range(1) ? ACT_POP_L : ACT_POP_R;
    end else begin
      case ($urandom_range(19))
        0, 1, 2:           c.action = ACT_PEEK_L;
        3, 4, 5:           c.action = ACT_PEEK_R;
        6, 7, 8, 9, 10:    c.action = ACT_GET;
        11, 12, 13, 14, 15: c.action = ACT_SET;
        16, 17:            c.action = ACT_REV;
        default:           c.action = 4'($urandom_range(ACT_CODE_MAX, ACT_FIRST_UNUSED));
      endcase
    end
    return c;
  endfunction

  // Sends one command beat. A random number of idle cycles may come first; valid
  // is only ever lowered at the start of a gap, so back-to-back beats keep it high.
  // The expected result is computed at the edge where the beat is taken.
  task automatic send_cmd(rrd_in_t c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    pending_results.push_back(predict_result(c));
  endtask

  // Holds the sender back until every owed result beat has come back.
  task automatic wait_for_results();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      flag_mismatch("result beats never arrived", pending_results.size(), 0);
      pending_results.delete();
    end
  endtask

  // Receiver side: random stall, changed once per edge.
  always @(posedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  // Every accepted result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result beat with nothing expected", out_data.word_out, 0);
      end else begin
        owed = pending_results.pop_front();
        if (out_data.word_out !== owed.word_out)
          flag_mismatch("word_out", out_data.word_out, owed.word_out);
        if (out_data.status !== owed.status)
          flag_mismatch("status", out_data.status, owed.status);
        if (out_data.occupancy !== owed.occupancy)
          flag_mismatch("occupancy", out_data.occupancy, owed.occupancy);
        if (out_data.is_empty !== owed.is_empty)
          flag_mismatch("is_empty", out_data.is_empty, owed.is_empty);
        if (out_data.reversed_now !== owed.reversed_now)
          flag_mismatch("reversed_now", out_data.reversed_now, owed.reversed_now);
      end
    end
  end

  // Every read and removal on an empty deque, a right peek also while reversed,
  // plus an out-of-range set at the top index and the highest unused action code.
  task automatic test_empty_queue();
    send_cmd(make_cmd(ACT_POP_L, 0, 0));
    send_cmd(make_cmd(ACT_POP_R, 0, 0));
    send_cmd(make_cmd(ACT_PEEK_L, 0, 0));
    send_cmd(make_cmd(ACT_PEEK_R, 0, 0));
    send_cmd(make_cmd(ACT_GET, 0, 0));
    send_cmd(make_cmd(ACT_SET, POS_MAX, WORD_MAX));
    send_cmd(make_cmd(ACT_CODE_MAX, POS_MAX, '1));
    send_cmd(make_cmd(ACT_REV, 0, 0));
    send_cmd(make_cmd(ACT_PEEK_R, 0, 0));
    send_cmd(make_cmd(ACT_REV, 0, 0));
    wait_for_results();
  endtask

  // Word extremes at both ends, indexed access across the edge of the length,
  // and the same ends seen through a reversal.
  task automatic test_ends_and_index();
    send_cmd(make_cmd(ACT_PUSH_L, 0, WORD_MIN));
    send_cmd(make_cmd(ACT_PUSH_R, 0, WORD_MAX));
    send_cmd(make_cmd(ACT_PUSH_L, 0, '1));
    send_cmd(make_cmd(ACT_PUSH_R, 0, 0));
    send_cmd(make_cmd(ACT_PEEK_L, 0, 0));
    send_cmd(make_cmd(ACT_PEEK_R, 0, 0));
    send_cmd(make_cmd(ACT_GET, 3, 0));
    send_cmd(make_cmd(ACT_GET, 4, 0));
    send_cmd(make_cmd(ACT_SET, 1, 64'sh5555_5555_5555_5555));
    send_cmd(make_cmd(ACT_GET, 1, 0));
    send_cmd(make_cmd(ACT_REV, 0, 0));
    send_cmd(make_cmd(ACT_PEEK_L, 0, 0));
    send_cmd(make_cmd(ACT_GET, 2, 0));
    send_cmd(make_cmd(ACT_PUSH_L, 0, 64'shAAAA_AAAA_AAAA_AAAA));
    send_cmd(make_cmd(ACT_POP_R, 0, 0));
    send_cmd(make_cmd(ACT_POP_L, 0, 0));
    wait_for_results();
  endtask

  // Mixed traffic around a small length, so the deque keeps running dry and
  // the pointers wrap at both ends of the ring.
  task automatic test_shallow_mix();
    for (int unsigned n = 0; n < 450; n++) begin
      send_cmd(next_random_cmd(30, 30));
      if (n % 150 == 149)
        wait_for_results();
    end
    wait_for_results();
  endtask

  // Fills the ring to capacity from random ends with reads mixed in. The first
  // stretch runs with neither side idling. Once full, pushes must be refused.
  task automatic test_fill_to_capacity();
    int unsigned n;
    n = 0;
    idle_pct = 0;
    stall_pct = 0;
    while (deque_len < CAP) begin
      if (n == 400) begin
        idle_pct = 37;
        stall_pct = 37;
      end
      if ($urandom_range(7) == 0)
        send_cmd(next_random_cmd(0, 0));
      else
        send_cmd(next_random_cmd(100, 0));
      n++;
    end
    send_cmd(make_cmd(ACT_PUSH_L, 0, WORD_MIN));
    send_cmd(make_cmd(ACT_PUSH_R, 0, WORD_MAX));
    send_cmd(make_cmd(ACT_GET, POS_MAX, 0));
    send_cmd(make_cmd(ACT_SET, POS_MAX, 64'sh0123_4567_89AB_CDEF));
    send_cmd(make_cmd(ACT_REV, 0, 0));
    send_cmd(make_cmd(ACT_PUSH_R, 0, 0));
    send_cmd(make_cmd(ACT_GET, 0, 0));
    send_cmd(make_cmd(ACT_PEEK_R, 0, 0));
    wait_for_results();
  endtask

  // Traffic on a nearly full ring, leaning toward removal.
  task automatic test_deep_mix();
    for (int unsigned n = 0; n < 400; n++) begin
      send_cmd(next_random_cmd(25, 40));
      if (n % 100 == 99)
        wait_for_results();
    end
    wait_for_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_ends_and_index();
    test_shallow_mix();
    test_fill_to_capacity();
    test_deep_mix();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Far beyond the slowest correct run of about two thousand beats.
  initial begin
    #4ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rrd_pkg.sv
rtl/rrd_ring.sv
rtl/rrd_ptr.sv
rtl/reversible_ring_deque_top.sv
tb/sv/tb_reversible_ring_deque_top.sv
